/* hdl/tcpf_pkg.sv */
package tcpf_pkg;

  // Fixed packet geometry and default store depths
  localparam int PacketQuads      = 16;
  localparam int HeadDepthDefault = 8;
  localparam int QuadDepthDefault = 128;

  // Stream payload widths
  localparam int InDataW  = 168;
  localparam int OutDataW = 168;
  localparam int BeatIdxW = 5;

  // Request codes
  typedef enum logic [3:0] {
    ReqNetHeader = 4'd0,
    ReqNetQuad   = 4'd1,
    ReqPopData   = 4'd2,
    ReqPopHeader = 4'd3,
    ReqPushData  = 4'd4,
    ReqPushHead  = 4'd5,
    ReqReadRx    = 4'd6,
    ReqReadInj   = 4'd7,
    ReqOrRx      = 4'd8,
    ReqOrInj     = 4'd9
  } req_e;

  // Beat kinds
  localparam logic [1:0] KindResp = 2'd0;
  localparam logic [1:0] KindHead = 2'd1;
  localparam logic [1:0] KindQuad = 2'd2;

  // Outcome codes
  localparam logic [1:0] OcOk        = 2'd0;
  localparam logic [1:0] OcUnderflow = 2'd1;
  localparam logic [1:0] OcOverflow  = 2'd2;
  localparam logic [1:0] OcDropped   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CfgRxWm      = 3'd0;
  localparam logic [2:0] CfgInjWm     = 3'd1;
  localparam logic [2:0] CfgRxEn      = 3'd2;
  localparam logic [2:0] CfgInjEn     = 3'd3;
  localparam logic [2:0] CfgRxCrit    = 3'd4;
  localparam logic [2:0] CfgInjCrit   = 3'd5;
  localparam logic [2:0] CfgRxNoncrit = 3'd6;
  localparam logic [2:0] CfgInjNoncrit = 3'd7;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StResp,
    StRead,
    StBeat
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic                latch_in;
    logic                exec;
    logic                show_resp;
    logic                rd;
    logic [BeatIdxW-1:0] idx;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic send;
  } dp_status_t;

endpackage

/* hdl/tree_channel_packet_fifos_unit.sv */
// Channel     | Direction | Handshake              | Payload
// s_axis      | in        | tvalid/tready          | tdata: request fields, tuser: req_type
// m_axis      | out       | tvalid/tready, tlast   | tdata: result fields, tuser: beat_kind
// cfg         | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One request is taken, executed in the next cycle, and its response beat then shown.
// A request that sends a packet then adds 17 link beats, each a read and then a show,
// set by the single read port of the inject stores; a plain access may stall on the output.
// The input is not ready again until the last beat of the current request is taken.
// Reset clears counts, pointers and flags at once; stores need no clearing pass.
// Configuration writes are taken in every cycle.
module tree_channel_packet_fifos_unit #(
  parameter int HEAD_DEPTH = tcpf_pkg::HeadDepthDefault,
  parameter int QUAD_DEPTH = tcpf_pkg::QuadDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // header_word[31:0], quad_high[95:32], quad_low[159:96], flag_bits[163:160]
  input  logic [tcpf_pkg::InDataW-1:0]  s_axis_tdata,
  // req_type[3:0]
  input  logic [3:0]                    s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // word_out[31:0], quad_out_high[95:32], quad_out_low[159:96], outcome[161:160],
  // rx_irq[162], inj_irq[163]
  output logic [tcpf_pkg::OutDataW-1:0] m_axis_tdata,
  // beat_kind[1:0]
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [2:0]                    cfg_index_i,
  input  logic [3:0]                    cfg_data_i
);
  import tcpf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  tcpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcpf_datapath #(
    .HeadDepth (HEAD_DEPTH),
    .QuadDepth (QUAD_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

/* hdl/tcpf_ctrl.sv */
module tcpf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  tcpf_pkg::dp_status_t status_i,
  output tcpf_pkg::dp_cmd_t   cmd_o
);
  import tcpf_pkg::*;

  ctrl_state_e         state_q, state_d;
  logic [BeatIdxW-1:0] idx_q, idx_d;

  // State and beat counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StExec;
      StExec: state_d = StResp;
      StResp: begin
        if (out_ready_i) begin
          idx_d   = '0;
          state_d = status_i.send ? StRead : StIdle;
        end
      end
      StRead: state_d = StBeat;
      StBeat: begin
        if (out_ready_i) begin
          if (idx_q == BeatIdxW'(PacketQuads)) begin
            state_d = StIdle;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = StRead;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o        = (state_q == StIdle);
    out_valid_o       = (state_q == StResp) || (state_q == StBeat);
    cmd_o.latch_in    = (state_q == StIdle) && in_valid_i;
    cmd_o.exec        = (state_q == StExec);
    cmd_o.show_resp   = (state_q == StResp);
    cmd_o.rd          = (state_q == StRead);
    cmd_o.idx         = idx_q;
  end

  // Checks
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= BeatIdxW'(PacketQuads)) else $error("beat index out of range");
  a_exec_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch_in |=> cmd_o.exec) else $error("accepted item not executed");
  a_read_before_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> (state_q == StBeat)) else $error("link read not followed by beat");

endmodule

/* hdl/tcpf_datapath.sv */
module tcpf_datapath #(
  parameter int HeadDepth = tcpf_pkg::HeadDepthDefault,
  parameter int QuadDepth = tcpf_pkg::QuadDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_index_i,
  input  logic [3:0]                    cfg_data_i,
  input  logic [tcpf_pkg::InDataW-1:0]  in_data_i,
  input  logic [3:0]                    in_user_i,
  input  tcpf_pkg::dp_cmd_t             cmd_i,
  output tcpf_pkg::dp_status_t          status_o,
  output logic [tcpf_pkg::OutDataW-1:0] out_data_o,
  output logic [1:0]                    out_user_o,
  output logic                          out_last_o
);
  import tcpf_pkg::*;

  localparam int HAW = (HeadDepth > 1) ? $clog2(HeadDepth) : 1;
  localparam int QAW = $clog2(QuadDepth);
  localparam int HCW = $clog2(HeadDepth + 1);
  localparam int QCW = $clog2(QuadDepth + 1);

  function automatic logic [HAW-1:0] hbump(input logic [HAW-1:0] p);
    return (p == HAW'(HeadDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [QAW-1:0] qadd(input logic [QAW-1:0] p,
                                          input logic [BeatIdxW-1:0] off);
    logic [QAW:0] s;
    s = {1'b0, p} + (QAW+1)'(off);
    if (s >= (QAW+1)'(QuadDepth)) s = s - (QAW+1)'(QuadDepth);
    return s[QAW-1:0];
  endfunction

  // Configuration registers
  logic [3:0] rx_wm_q, inj_wm_q, inj_en_q, inj_crit_q, inj_nc_q;
  logic [2:0] rx_en_q, rx_crit_q, rx_nc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wm_q    <= '0;
      inj_wm_q   <= '0;
      rx_en_q    <= '0;
      inj_en_q   <= '0;
      rx_crit_q  <= 3'd7;
      inj_crit_q <= 4'd7;
      rx_nc_q    <= '0;
      inj_nc_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRxWm:       rx_wm_q    <= cfg_data_i;
        CfgInjWm:      inj_wm_q   <= cfg_data_i;
        CfgRxEn:       rx_en_q    <= cfg_data_i[2:0];
        CfgInjEn:      inj_en_q   <= cfg_data_i;
        CfgRxCrit:     rx_crit_q  <= cfg_data_i[2:0];
        CfgInjCrit:    inj_crit_q <= cfg_data_i;
        CfgRxNoncrit:  rx_nc_q    <= cfg_data_i[2:0];
        CfgInjNoncrit: inj_nc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latched input beat
  logic [3:0]  req_q;
  logic [31:0] hw_q;
  logic [63:0] qh_q, ql_q;
  logic [3:0]  fb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      req_q <= in_user_i;
      hw_q  <= in_data_i[31:0];
      qh_q  <= in_data_i[95:32];
      ql_q  <= in_data_i[159:96];
      fb_q  <= in_data_i[163:160];
    end
  end

  // Channel state
  logic [HCW-1:0] rhc_q, rhc_d, ihc_q, ihc_d;
  logic [QCW-1:0] rqc_q, rqc_d, iqc_q, iqc_d;
  logic [HAW-1:0] rh_wp_q, rh_wp_d, rh_rp_q, rh_rp_d;
  logic [HAW-1:0] ih_wp_q, ih_wp_d, ih_rp_q, ih_rp_d;
  logic [QAW-1:0] rq_wp_q, rq_wp_d, rq_rp_q, rq_rp_d;
  logic [QAW-1:0] iq_wp_q, iq_wp_d, iq_rp_q, iq_rp_d;
  logic [2:0]     rxf_q, rxf_d;
  logic [3:0]     injf_q, injf_d;
  logic [4:0]     bl_q, bl_d;
  logic           acc_q, acc_d;
  logic           send_q, send_d;
  logic [HAW-1:0] s_hp_q, s_hp_d;
  logic [QAW-1:0] s_qp_q, s_qp_d;
  logic [31:0]    word_q, word_d;
  logic           pop_h_q, pop_h_d, pop_q_q, pop_q_d;
  logic [1:0]     oc_q, oc_d;
  logic           rx_irq_q, rx_irq_d, inj_irq_q, inj_irq_d;

  // Memory port controls
  logic           rqm_we, rqm_re, iqm_we, iqm_re;
  logic           rhm_we, rhm_re, ihm_we, ihm_re;
  logic [QAW-1:0] rqm_wa, iqm_ra;
  logic [HAW-1:0] rhm_wa;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rhc_q <= '0; ihc_q <= '0; rqc_q <= '0; iqc_q <= '0;
      rh_wp_q <= '0; rh_rp_q <= '0; ih_wp_q <= '0; ih_rp_q <= '0;
      rq_wp_q <= '0; rq_rp_q <= '0; iq_wp_q <= '0; iq_rp_q <= '0;
      rxf_q <= '0; injf_q <= '0; bl_q <= '0; acc_q <= 1'b0;
      send_q <= 1'b0; pop_h_q <= 1'b0; pop_q_q <= 1'b0;
      rx_irq_q <= 1'b0; inj_irq_q <= 1'b0;
    end else if (cmd_i.exec) begin
      rhc_q <= rhc_d; ihc_q <= ihc_d; rqc_q <= rqc_d; iqc_q <= iqc_d;
      rh_wp_q <= rh_wp_d; rh_rp_q <= rh_rp_d;
      ih_wp_q <= ih_wp_d; ih_rp_q <= ih_rp_d;
      rq_wp_q <= rq_wp_d; rq_rp_q <= rq_rp_d;
      iq_wp_q <= iq_wp_d; iq_rp_q <= iq_rp_d;
      rxf_q <= rxf_d; injf_q <= injf_d; bl_q <= bl_d; acc_q <= acc_d;
      send_q <= send_d; pop_h_q <= pop_h_d; pop_q_q <= pop_q_d;
      rx_irq_q <= rx_irq_d; inj_irq_q <= inj_irq_d;
    end
  end

  // Response payload and send pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      word_q <= word_d;
      oc_q   <= oc_d;
      s_hp_q <= s_hp_d;
      s_qp_q <= s_qp_d;
    end
  end

  // One request step
  always_comb begin
    rhc_d = rhc_q; ihc_d = ihc_q; rqc_d = rqc_q; iqc_d = iqc_q;
    rh_wp_d = rh_wp_q; rh_rp_d = rh_rp_q; ih_wp_d = ih_wp_q; ih_rp_d = ih_rp_q;
    rq_wp_d = rq_wp_q; rq_rp_d = rq_rp_q; iq_wp_d = iq_wp_q; iq_rp_d = iq_rp_q;
    rxf_d = rxf_q; injf_d = injf_q; bl_d = bl_q; acc_d = acc_q;
    send_d = 1'b0; s_hp_d = ih_rp_q; s_qp_d = iq_rp_q;
    word_d = '0; pop_h_d = 1'b0; pop_q_d = 1'b0; oc_d = OcOk;
    rqm_we = 1'b0; rqm_re = 1'b0; iqm_we = 1'b0;
    rhm_we = 1'b0; rhm_re = 1'b0; ihm_we = 1'b0;
    rqm_wa = qadd(rq_wp_q, BeatIdxW'(PacketQuads) - bl_q);
    rhm_wa = rh_wp_q;
    if (cmd_i.exec) begin
      unique case (req_q)
        ReqNetHeader: begin
          bl_d  = 5'(PacketQuads);
          acc_d = (rhc_q < HCW'(HeadDepth)) &&
                  (({1'b0, rqc_q} + (QCW+1)'(PacketQuads)) <= (QCW+1)'(QuadDepth));
          if (acc_d) rhm_we = 1'b1;
          else oc_d = OcDropped;
        end
        ReqNetQuad: begin
          if (bl_q == '0) begin
            oc_d = OcDropped;
          end else if (!acc_q) begin
            bl_d = bl_q - 1'b1;
            oc_d = OcDropped;
          end else begin
            rqm_we = 1'b1;
            bl_d   = bl_q - 1'b1;
            if (bl_d == '0) begin
              acc_d   = 1'b0;
              rh_wp_d = hbump(rh_wp_q);
              rq_wp_d = qadd(rq_wp_q, BeatIdxW'(PacketQuads));
              rhc_d   = rhc_q + 1'b1;
              rqc_d   = rqc_q + QCW'(PacketQuads);
              if ((rqc_d >> 4) > QCW'(rx_wm_q)) rxf_d[0] = 1'b1;
            end
          end
        end
        ReqPopData: begin
          if (rqc_q == '0) begin
            rxf_d[1] = 1'b1;
            oc_d     = OcUnderflow;
          end else begin
            rqm_re  = 1'b1;
            pop_q_d = 1'b1;
            rq_rp_d = qadd(rq_rp_q, BeatIdxW'(1));
            rqc_d   = rqc_q - 1'b1;
            if ((rqc_d >> 4) <= QCW'(rx_wm_q)) rxf_d[0] = 1'b0;
          end
        end
        ReqPopHeader: begin
          if (rhc_q == '0) begin
            rxf_d[2] = 1'b1;
            oc_d     = OcUnderflow;
          end else begin
            rhm_re  = 1'b1;
            pop_h_d = 1'b1;
            rh_rp_d = hbump(rh_rp_q);
            rhc_d   = rhc_q - 1'b1;
          end
        end
        ReqPushData: begin
          if (iqc_q >= QCW'(QuadDepth)) begin
            injf_d[1] = 1'b1;
            oc_d      = OcOverflow;
          end else begin
            iqm_we  = 1'b1;
            iq_wp_d = qadd(iq_wp_q, BeatIdxW'(1));
            iqc_d   = iqc_q + 1'b1;
            if ((iqc_d >> 4) > QCW'(inj_wm_q)) injf_d[0] = 1'b0;
            send_d  = 1'b1;
          end
        end
        ReqPushHead: begin
          if (ihc_q >= HCW'(HeadDepth)) begin
            injf_d[2] = 1'b1;
            oc_d      = OcOverflow;
          end else begin
            ihm_we  = 1'b1;
            ih_wp_d = hbump(ih_wp_q);
            ihc_d   = ihc_q + 1'b1;
            send_d  = 1'b1;
          end
        end
        ReqReadRx: begin
          word_d = {29'd0, rxf_q};
          rxf_d  = rxf_q & 3'b001;
        end
        ReqReadInj: begin
          word_d = {28'd0, injf_q};
          injf_d = injf_q & 4'b1001;
        end
        ReqOrRx:  rxf_d  = rxf_q | fb_q[2:0];
        ReqOrInj: injf_d = injf_q | fb_q;
        default: ;
      endcase
      // Send a queued packet after a successful push
      if (send_d) begin
        send_d = (inj_en_q[3] | injf_d[3]) && (ihc_d != '0) &&
                 (iqc_d >= QCW'(PacketQuads));
        if (send_d) begin
          ih_rp_d = hbump(ih_rp_q);
          ihc_d   = ihc_d - 1'b1;
          iq_rp_d = qadd(iq_rp_q, BeatIdxW'(PacketQuads));
          iqc_d   = iqc_d - QCW'(PacketQuads);
          if ((iqc_d >> 4) <= QCW'(inj_wm_q)) injf_d[0] = 1'b1;
        end
      end
      if (((rxf_d & rx_nc_q) != '0) || ((injf_d & inj_nc_q) != '0)) injf_d[3] = 1'b0;
    end
    rx_irq_d  = (rxf_d & rx_en_q & rx_crit_q) != '0;
    inj_irq_d = (injf_d & inj_en_q & inj_crit_q) != '0;
  end

  // Link read during send
  always_comb begin
    ihm_re = cmd_i.rd && (cmd_i.idx == '0);
    iqm_re = cmd_i.rd && (cmd_i.idx != '0);
    iqm_ra = qadd(s_qp_q, cmd_i.idx - 1'b1);
  end

  // Stores
  logic [127:0] rq_mem [QuadDepth];
  logic [127:0] iq_mem [QuadDepth];
  logic [31:0]  rh_mem [HeadDepth];
  logic [31:0]  ih_mem [HeadDepth];
  logic [127:0] rq_rd_q, iq_rd_q;
  logic [31:0]  rh_rd_q, ih_rd_q;

  always_ff @(posedge clk_i) begin
    if (rqm_we) rq_mem[rqm_wa] <= {qh_q, ql_q};
    if (rqm_re) rq_rd_q <= rq_mem[rq_rp_q];
  end

  always_ff @(posedge clk_i) begin
    if (iqm_we) iq_mem[iq_wp_q] <= {qh_q, ql_q};
    if (iqm_re) iq_rd_q <= iq_mem[iqm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rhm_we) rh_mem[rhm_wa] <= hw_q;
    if (rhm_re) rh_rd_q <= rh_mem[rh_rp_q];
  end

  always_ff @(posedge clk_i) begin
    if (ihm_we) ih_mem[ih_wp_q] <= hw_q;
    if (ihm_re) ih_rd_q <= ih_mem[s_hp_q];
  end

  // Output beat
  logic [31:0]  o_word;
  logic [127:0] o_quad;
  logic [1:0]   o_oc;

  always_comb begin
    if (cmd_i.show_resp) begin
      out_user_o = KindResp;
      o_word     = pop_h_q ? rh_rd_q : word_q;
      o_quad     = pop_q_q ? rq_rd_q : '0;
      o_oc       = oc_q;
      out_last_o = !send_q;
    end else if (cmd_i.idx == '0) begin
      out_user_o = KindHead;
      o_word     = ih_rd_q;
      o_quad     = '0;
      o_oc       = OcOk;
      out_last_o = 1'b0;
    end else begin
      out_user_o = KindQuad;
      o_word     = '0;
      o_quad     = iq_rd_q;
      o_oc       = OcOk;
      out_last_o = (cmd_i.idx == BeatIdxW'(PacketQuads));
    end
    out_data_o = {4'd0, inj_irq_q, rx_irq_q, o_oc, o_quad[63:0], o_quad[127:64], o_word};
  end

  assign status_o.send = send_q;

  // Checks
  a_rqc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rqc_q <= QCW'(QuadDepth)) else $error("receive quad count overrun");
  a_ihc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ihc_q <= HCW'(HeadDepth)) else $error("inject head count overrun");
  a_bl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bl_q <= 5'(PacketQuads)) else $error("incoming beat count overrun");
  a_send_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && send_d) |=> send_q)
    else $error("packet send not recorded");

endmodule
